>>> hw/rtl/pebl_pkg.sv
package pebl_pkg;

  // default store size in bytes
  localparam int PEBL_BUFFER_BYTES = 64;

  // item modes
  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_VERDICT = 2'd1;
  localparam logic [1:0] MODE_ABORT   = 2'd2;

  // key kinds
  localparam logic [2:0] KIND_CHAR      = 3'd0;
  localparam logic [2:0] KIND_ESCAPE    = 3'd1;
  localparam logic [2:0] KIND_BACKSPACE = 3'd2;
  localparam logic [2:0] KIND_ENTER     = 3'd3;

  // config register indexes
  localparam logic [2:0] REG_BASE_DELAY  = 3'd0;
  localparam logic [2:0] REG_GROWTH      = 3'd1;
  localparam logic [2:0] REG_MAX_DELAY   = 3'd2;
  localparam logic [2:0] REG_MIN_WRONG   = 3'd3;
  localparam logic [2:0] REG_LOCKOUT     = 3'd4;
  localparam logic [2:0] REG_WIPE_ON_BS  = 3'd5;

  // config reset values
  localparam logic [31:0] RST_BASE_DELAY = 32'd1000;
  localparam logic [7:0]  RST_GROWTH     = 8'd2;
  localparam logic [31:0] RST_MAX_DELAY  = 32'd60000;
  localparam logic [31:0] RST_MIN_WRONG  = 32'd1000;

  // codepoint limits and UTF-8 marks
  localparam logic [20:0] CP_FIRST_PRINT = 21'h20;
  localparam logic [20:0] CP_DELETE      = 21'h7f;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO     = 21'hD800;
  localparam logic [20:0] CP_SURR_HI     = 21'hDFFF;
  localparam logic [20:0] CP_TWO_BYTE    = 21'h80;
  localparam logic [20:0] CP_THREE_BYTE  = 21'h800;
  localparam logic [20:0] CP_FOUR_BYTE   = 21'h10000;
  localparam logic [7:0]  UTF8_CONT      = 8'h80;
  localparam logic [7:0]  UTF8_TOP_MASK  = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4     = 8'hF0;

  localparam logic [15:0] FAIL_MAX = 16'hFFFF;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic wrong_release;
    logic clear_store;
    logic add_write;
    logic bs_start;
    logic bs_step;
    logic bs_finish;
    logic stream_start;
    logic stream_emit;
    logic verdict_accept;
    logic verdict_reject;
    logic bo_step;
    logic bo_clamp;
    logic set_deadline;
    logic abort;
    logic emit_status;
  } pebl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       item_key;
    logic       item_verdict;
    logic       item_abort;
    logic [2:0] key_kind;
    logic       verdict_ok;
    logic       len_zero;
    logic       throttled;
    logic       pending;
    logic       wipe;
    logic       cp_fit;
    logic       add_last;
    logic       bs_more;
    logic       stream_last;
    logic       bo_more;
    logic       out_free;
  } pebl_sts_t;

  // printable, encodable codepoint
  function automatic logic cp_usable(input logic [20:0] cp);
    logic surr;
    surr = (cp inside {[CP_SURR_LO:CP_SURR_HI]});
    return !(cp < CP_FIRST_PRINT || cp == CP_DELETE || cp > CP_MAX || surr);
  endfunction

  // UTF-8 length, 1 to 4
  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < CP_TWO_BYTE)        n = 3'd1;
    else if (cp < CP_THREE_BYTE) n = 3'd2;
    else if (cp < CP_FOUR_BYTE)  n = 3'd3;
    else                         n = 3'd4;
    return n;
  endfunction

  // byte idx of the UTF-8 encoding of cp (n bytes long)
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = cp[7:0];
    case (n)
      3'd2: begin
        case (idx)
          2'd0:    b = UTF8_LEAD2 | {3'b000, cp[10:6]};
          default: b = UTF8_CONT | {2'b00, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (idx)
          2'd0:    b = UTF8_LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = UTF8_CONT | {2'b00, cp[11:6]};
          default: b = UTF8_CONT | {2'b00, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0:    b = UTF8_LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = UTF8_CONT | {2'b00, cp[17:12]};
          2'd2:    b = UTF8_CONT | {2'b00, cp[11:6]};
          default: b = UTF8_CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/pebl_ctrl.sv
module pebl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                cfg_ready,
  input  pebl_pkg::pebl_sts_t sts,
  output pebl_pkg::pebl_cmd_t cmd
);
  import pebl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_BS_CHK,
    S_STREAM,
    S_BO_LOOP,
    S_BO_CLAMP,
    S_DEADLINE,
    S_STATUS
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_STATUS;
        if (sts.item_key) begin
          cmd.wrong_release = 1'b1;
          case (sts.key_kind)
            KIND_ESCAPE: cmd.clear_store = 1'b1;
            KIND_BACKSPACE: begin
              if (!sts.len_zero) begin
                if (sts.wipe) begin
                  cmd.clear_store = 1'b1;
                end else begin
                  cmd.bs_start = 1'b1;
                  state_next   = S_BS_CHK;
                end
              end
            end
            KIND_ENTER: begin
              if (!sts.len_zero && !sts.throttled && !sts.pending) begin
                cmd.stream_start = 1'b1;
                state_next       = S_STREAM;
              end
            end
            KIND_CHAR: begin
              if (sts.cp_fit) state_next = S_ADD;
            end
            default: state_next = S_STATUS;
          endcase
        end else if (sts.item_verdict) begin
          if (sts.pending) begin
            if (sts.verdict_ok) begin
              cmd.verdict_accept = 1'b1;
            end else begin
              cmd.verdict_reject = 1'b1;
              state_next         = S_BO_LOOP;
            end
          end
        end else if (sts.item_abort) begin
          cmd.abort = 1'b1;
        end
      end
      S_ADD: begin
        cmd.add_write = 1'b1;
        if (sts.add_last) state_next = S_STATUS;
      end
      S_BS_CHK: begin
        if (sts.bs_more) begin
          cmd.bs_step = 1'b1;
        end else begin
          cmd.bs_finish = 1'b1;
          state_next    = S_STATUS;
        end
      end
      S_STREAM: begin
        if (sts.out_free) begin
          cmd.stream_emit = 1'b1;
          if (sts.stream_last) state_next = S_IDLE;
        end
      end
      S_BO_LOOP: begin
        if (sts.bo_more) cmd.bo_step = 1'b1;
        else             state_next  = S_BO_CLAMP;
      end
      S_BO_CLAMP: begin
        cmd.bo_clamp = 1'b1;
        state_next   = S_DEADLINE;
      end
      S_DEADLINE: begin
        cmd.set_deadline = 1'b1;
        state_next       = S_STATUS;
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      cfg_ready <= 1'b1;
    end else begin
      state     <= state_next;
      in_stall  <= (state_next != S_IDLE);
      cfg_ready <= (state_next == S_IDLE);
    end
  end

endmodule

>>> hw/rtl/pebl_dp.sv
module pebl_dp #(
  parameter int BUFFER_BYTES = pebl_pkg::PEBL_BUFFER_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  // input word
  input  logic [1:0]          mode,
  input  logic                key_pressed,
  input  logic [2:0]          key_kind,
  input  logic [20:0]         codepoint,
  input  logic                verdict_ok,
  input  logic [47:0]         now_ms,
  // config
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // control
  input  pebl_pkg::pebl_cmd_t cmd,
  output pebl_pkg::pebl_sts_t sts,
  // result word
  input  logic                out_stall,
  output logic                out_valid,
  output logic                result_kind,
  output logic [7:0]          password_byte,
  output logic                last_byte,
  output logic [5:0]          typed_count,
  output logic                wrong_shown,
  output logic                throttled_now,
  output logic                lockout_active,
  output logic                awaiting_verdict,
  output logic                unlocked
);
  import pebl_pkg::*;

  localparam int LW = $clog2(BUFFER_BYTES);

  // config registers
  logic [31:0] base_delay_ms, max_delay_ms, min_wrong_ms;
  logic [7:0]  delay_growth;
  logic [15:0] lockout_count;
  logic        bs_wipe;

  // latched item
  logic [1:0]  mode_q;
  logic        pressed_q;
  logic [2:0]  kind_q;
  logic [20:0] cp_q;
  logic        ok_q;
  logic [47:0] now_q;

  // byte store
  logic [7:0]  byte_store [BUFFER_BYTES];
  logic [7:0]  rd_data;

  // block state
  logic [LW-1:0] byte_length;
  logic [5:0]    codepoint_total;
  logic          wrong_flag;
  logic [15:0]   failure_count;
  logic [47:0]   retry_deadline;
  logic          verdict_pending;
  logic          unl_flag;

  // working registers
  logic [LW-1:0] ptr, ptr_next, stream_len;
  logic [1:0]    add_cnt;
  logic [39:0]   delay;
  logic [15:0]   iter;

  // derived values
  logic          cp_ok, throttled, locked;
  logic [2:0]    cp_nbytes;
  logic [LW:0]   fit_sum;
  logic [39:0]   delay_prod;
  logic [31:0]   delay_clamped;
  logic [48:0]   deadline_sum;

  assign cp_ok      = cp_usable(cp_q);
  assign cp_nbytes  = utf8_len(cp_q);
  assign fit_sum    = {1'b0, byte_length} + (LW + 1)'(cp_nbytes);
  assign throttled  = now_q < retry_deadline;
  assign locked     = (lockout_count != '0) && (failure_count >= lockout_count);
  assign delay_prod = {8'b0, delay[31:0]} * {32'b0, delay_growth};
  assign deadline_sum = {1'b0, now_q} + {17'b0, delay[31:0]};

  // clamp of the grown delay
  always_comb begin
    if (locked) begin
      delay_clamped = max_delay_ms;
    end else begin
      if (delay > {8'b0, max_delay_ms}) delay_clamped = max_delay_ms;
      else                              delay_clamped = delay[31:0];
      if (delay_clamped < min_wrong_ms) delay_clamped = min_wrong_ms;
    end
  end

  // status to the controller
  always_comb begin
    sts              = '0;
    sts.item_key     = (mode_q == MODE_KEY) && pressed_q && (kind_q <= KIND_ENTER);
    sts.item_verdict = (mode_q == MODE_VERDICT);
    sts.item_abort   = (mode_q == MODE_ABORT);
    sts.key_kind     = kind_q;
    sts.verdict_ok   = ok_q;
    sts.len_zero     = (byte_length == '0);
    sts.throttled    = throttled;
    sts.pending      = verdict_pending;
    sts.wipe         = bs_wipe;
    sts.cp_fit       = cp_ok && (fit_sum < (LW + 1)'(BUFFER_BYTES));
    sts.add_last     = ({1'b0, add_cnt} == cp_nbytes - 3'd1);
    sts.bs_more      = (ptr != '0) && ((rd_data & UTF8_TOP_MASK) == UTF8_CONT);
    sts.stream_last  = (ptr == stream_len - LW'(1));
    sts.bo_more      = !locked && (delay_growth > 8'd1) && (iter < failure_count) &&
                       (delay < {8'b0, max_delay_ms}) && (delay != '0);
    sts.out_free     = !out_valid || !out_stall;
  end

  // store pointer: read data always follows the registered pointer
  always_comb begin
    ptr_next = ptr;
    if (cmd.bs_start)          ptr_next = byte_length - LW'(1);
    else if (cmd.bs_step)      ptr_next = ptr - LW'(1);
    else if (cmd.stream_start) ptr_next = '0;
    else if (cmd.stream_emit)  ptr_next = ptr + LW'(1);
  end

  // byte store memory
  always_ff @(posedge clk) begin
    if (cmd.add_write) byte_store[byte_length] <= utf8_byte(cp_q, cp_nbytes, add_cnt);
    rd_data <= byte_store[ptr_next];
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay_ms     <= RST_BASE_DELAY;
      delay_growth      <= RST_GROWTH;
      max_delay_ms      <= RST_MAX_DELAY;
      min_wrong_ms      <= RST_MIN_WRONG;
      lockout_count     <= '0;
      bs_wipe           <= 1'b0;
      byte_length       <= '0;
      codepoint_total   <= '0;
      wrong_flag        <= 1'b0;
      failure_count     <= '0;
      retry_deadline    <= '0;
      verdict_pending   <= 1'b0;
      unl_flag          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_DELAY: base_delay_ms     <= cfg_data;
          REG_GROWTH:     delay_growth      <= cfg_data[7:0];
          REG_MAX_DELAY:  max_delay_ms      <= cfg_data;
          REG_MIN_WRONG:  min_wrong_ms      <= cfg_data;
          REG_LOCKOUT:    lockout_count     <= cfg_data[15:0];
          REG_WIPE_ON_BS: bs_wipe           <= cfg_data[0];
          default: ;
        endcase
      end

      // store length and codepoint count
      if (cmd.clear_store || cmd.stream_start || cmd.verdict_accept || cmd.abort) begin
        byte_length     <= '0;
        codepoint_total <= '0;
      end else if (cmd.add_write) begin
        byte_length <= byte_length + LW'(1);
        if (sts.add_last) codepoint_total <= codepoint_total + 6'd1;
      end else if (cmd.bs_finish) begin
        byte_length <= ptr;
        if (codepoint_total != '0) codepoint_total <= codepoint_total - 6'd1;
      end

      // wrong flag
      if (cmd.verdict_reject) wrong_flag <= 1'b1;
      else if (cmd.verdict_accept || cmd.abort) wrong_flag <= 1'b0;
      else if (cmd.wrong_release && !throttled) wrong_flag <= 1'b0;

      // failure count, saturating
      if (cmd.verdict_accept || cmd.abort) failure_count <= '0;
      else if (cmd.verdict_reject && failure_count != FAIL_MAX)
        failure_count <= failure_count + 16'd1;

      // retry deadline, saturating add
      if (cmd.verdict_accept || cmd.abort) retry_deadline <= '0;
      else if (cmd.set_deadline)
        retry_deadline <= deadline_sum[48] ? TIME_MAX : deadline_sum[47:0];

      if (cmd.stream_start) verdict_pending <= 1'b1;
      else if (cmd.verdict_accept || cmd.verdict_reject || cmd.abort) verdict_pending <= 1'b0;

      if (cmd.latch) unl_flag <= 1'b0;
      else if (cmd.verdict_accept) unl_flag <= 1'b1;

      // output register valid
      if (cmd.emit_status || cmd.stream_emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.latch) begin
      mode_q    <= mode;
      pressed_q <= key_pressed;
      kind_q    <= key_kind;
      cp_q      <= codepoint;
      ok_q      <= verdict_ok;
      now_q     <= now_ms;
      add_cnt   <= '0;
    end else if (cmd.add_write) begin
      add_cnt <= add_cnt + 2'd1;
    end
    if (cmd.stream_start) stream_len <= byte_length;

    // backoff: one multiply per cycle
    if (cmd.verdict_reject) begin
      delay <= {8'b0, base_delay_ms};
      iter  <= 16'd1;
    end else if (cmd.bo_step) begin
      delay <= delay_prod;
      iter  <= iter + 16'd1;
    end else if (cmd.bo_clamp) begin
      delay <= {8'b0, delay_clamped};
    end

    // result word
    if (cmd.emit_status || cmd.stream_emit) begin
      result_kind      <= cmd.stream_emit;
      password_byte    <= cmd.stream_emit ? rd_data : 8'd0;
      last_byte        <= cmd.stream_emit && sts.stream_last;
      typed_count      <= codepoint_total;
      wrong_shown      <= wrong_flag;
      throttled_now    <= throttled;
      lockout_active   <= locked;
      awaiting_verdict <= verdict_pending;
      unlocked         <= cmd.emit_status && unl_flag;
    end
  end

endmodule

>>> hw/rtl/password_entry_backoff_lock.sv
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------------
// in       in_valid / in_stall    mode key_pressed key_kind codepoint verdict_ok
//                                 now_ms
// out      out_valid / out_stall  result_kind password_byte last_byte typed_count
//                                 wrong_shown throttled_now lockout_active
//                                 awaiting_verdict unlocked
// cfg      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One input word at a time. A status-only word passes the decode and status states;
// a character adds a write step per UTF-8 byte, backspace a step per removed byte.
// Enter streams one byte per cycle from the store while the output is not stalled.
// A rejecting verdict runs the backoff multiply steps, at most 32 steps, then the
// clamp and deadline states. Synchronous reset loads config defaults and empties
// the store; no clearing pass. out_stall holds the output register and the block.
module password_entry_backoff_lock #(
  parameter int BUFFER_BYTES = pebl_pkg::PEBL_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        key_pressed,
  input  logic [2:0]  key_kind,
  input  logic [20:0] codepoint,
  input  logic        verdict_ok,
  input  logic [47:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  password_byte,
  output logic        last_byte,
  output logic [5:0]  typed_count,
  output logic        wrong_shown,
  output logic        throttled_now,
  output logic        lockout_active,
  output logic        awaiting_verdict,
  output logic        unlocked,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pebl_pkg::*;

  pebl_cmd_t cmd;
  pebl_sts_t sts;

  // sequencer
  pebl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, backoff and output register
  pebl_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .mode             (mode),
    .key_pressed      (key_pressed),
    .key_kind         (key_kind),
    .codepoint        (codepoint),
    .verdict_ok       (verdict_ok),
    .now_ms           (now_ms),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .result_kind      (result_kind),
    .password_byte    (password_byte),
    .last_byte        (last_byte),
    .typed_count      (typed_count),
    .wrong_shown      (wrong_shown),
    .throttled_now    (throttled_now),
    .lockout_active   (lockout_active),
    .awaiting_verdict (awaiting_verdict),
    .unlocked         (unlocked)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pebl_pkg::*;

  localparam int          STORE_BYTES    = PEBL_BUFFER_BYTES;
  localparam int          CYCLE_LIMIT    = 2_000_000;
  localparam int          DRAIN_CYCLES   = 48;
  localparam int          MAX_GAP        = 40;
  localparam logic [1:0]  MODE_UNKNOWN   = 2'd3;
  localparam logic [2:0]  KIND_MODIFIER  = 3'd4;
  localparam logic [2:0]  KIND_RESERVED  = 3'd7;
  localparam logic        WORD_STATUS    = 1'b0;
  localparam logic        WORD_PW_BYTE   = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic        key_pressed;
    logic [2:0]  key_kind;
    logic [20:0] codepoint;
    logic        verdict_ok;
    logic [47:0] now_ms;
  } entry_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] password_byte;
    logic       last_byte;
    logic [5:0] typed_count;
    logic       wrong_shown;
    logic       throttled_now;
    logic       lockout_active;
    logic       awaiting_verdict;
    logic       unlocked;
  } lock_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic        key_pressed;
  logic [2:0]  key_kind;
  logic [20:0] codepoint;
  logic        verdict_ok;
  logic [47:0] now_ms;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [7:0]  password_byte;
  logic        last_byte;
  logic [5:0]  typed_count;
  logic        wrong_shown;
  logic        throttled_now;
  logic        lockout_active;
  logic        awaiting_verdict;
  logic        unlocked;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  password_entry_backoff_lock u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .key_pressed      (key_pressed),
    .key_kind         (key_kind),
    .codepoint        (codepoint),
    .verdict_ok       (verdict_ok),
    .now_ms           (now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .password_byte    (password_byte),
    .last_byte        (last_byte),
    .typed_count      (typed_count),
    .wrong_shown      (wrong_shown),
    .throttled_now    (throttled_now),
    .lockout_active   (lockout_active),
    .awaiting_verdict (awaiting_verdict),
    .unlocked         (unlocked),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // lock state mirror
  logic [7:0]  pw_store [STORE_BYTES];
  int          pw_len;
  logic [5:0]  pw_count;
  logic        lock_wrong;
  logic [15:0] lock_fails;
  logic [47:0] lock_deadline;
  logic        lock_pending;

  // register mirror
  logic [31:0] cfg_base = RST_BASE_DELAY;
  logic [7:0]  cfg_growth = RST_GROWTH;
  logic [31:0] cfg_max = RST_MAX_DELAY;
  logic [31:0] cfg_min = RST_MIN_WRONG;
  logic [15:0] cfg_lockout = 16'd0;
  logic        cfg_wipe = 1'b0;

  lock_word_t  lock_words [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          fed_words = 0;
  logic [47:0] cur_ms = 48'd0;

  function automatic void clear_pw();
    pw_len   = 0;
    pw_count = 6'd0;
  endfunction

  function automatic logic is_locked();
    return (cfg_lockout != 16'd0) && (lock_fails >= cfg_lockout);
  endfunction

  function automatic lock_word_t status_of(input logic kind, input logic [7:0] b,
                                           input logic last, input logic unl,
                                           input logic [47:0] now);
    lock_word_t w;
    w.result_kind      = kind;
    w.password_byte    = b;
    w.last_byte        = last;
    w.typed_count      = pw_count;
    w.wrong_shown      = lock_wrong;
    w.throttled_now    = now < lock_deadline;
    w.lockout_active   = is_locked();
    w.awaiting_verdict = lock_pending;
    w.unlocked         = unl;
    return w;
  endfunction

  // UTF-8 sequence packed low byte first, returns byte count
  function automatic int cp_utf8_seq(input logic [20:0] cp, output logic [31:0] seq);
    seq = 32'd0;
    if (cp < CP_TWO_BYTE) begin
      seq[7:0] = cp[7:0];
      return 1;
    end
    if (cp < CP_THREE_BYTE) begin
      seq[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
      return 2;
    end
    if (cp < CP_FOUR_BYTE) begin
      seq[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      return 3;
    end
    seq = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    return 4;
  endfunction

  function automatic logic [63:0] backoff_ms();
    logic [63:0] d;
    logic [63:0] g;
    int          i;
    if (is_locked()) return {32'd0, cfg_max};
    d = {32'd0, cfg_base};
    g = (cfg_growth < 8'd1) ? 64'd1 : {56'd0, cfg_growth};
    if (g > 64'd1)
      for (i = 1; i < lock_fails && d < {32'd0, cfg_max}; i++) d = d * g;
    if (d > {32'd0, cfg_max}) d = {32'd0, cfg_max};
    if (d < {32'd0, cfg_min}) d = {32'd0, cfg_min};
    return d;
  endfunction

  // advance the lock mirror by one accepted entry and queue the words it causes
  function automatic void lock_update(input entry_t e);
    logic [31:0] seq;
    logic [63:0] d;
    logic [7:0]  snap [STORE_BYTES];
    int          n;
    int          k;
    int          nl;
    logic        unl;
    unl = 1'b0;
    if (e.mode == MODE_KEY && e.key_pressed && e.key_kind <= KIND_ENTER) begin
      if (lock_wrong && !(e.now_ms < lock_deadline)) lock_wrong = 1'b0;
      case (e.key_kind)
        KIND_ESCAPE: clear_pw();
        KIND_BACKSPACE: begin
          if (pw_len > 0) begin
            if (cfg_wipe) begin
              clear_pw();
            end else begin
              nl = pw_len - 1;
              while (nl > 0 && (pw_store[nl] & UTF8_TOP_MASK) == UTF8_CONT) nl--;
              pw_len = nl;
              if (pw_count > 0) pw_count--;
            end
          end
        end
        KIND_ENTER: begin
          if (pw_len > 0 && !(e.now_ms < lock_deadline) && !lock_pending) begin
            n = pw_len;
            for (k = 0; k < n; k++) snap[k] = pw_store[k];
            clear_pw();
            lock_pending = 1'b1;
            for (k = 0; k < n; k++)
              lock_words.push_back(status_of(WORD_PW_BYTE, snap[k], k == n - 1, 1'b0,
                                             e.now_ms));
            return;
          end
        end
        default: begin
          // printable codepoints only, and only while they fit
          if (!(e.codepoint < CP_FIRST_PRINT || e.codepoint == CP_DELETE ||
                e.codepoint > CP_MAX ||
                (e.codepoint >= CP_SURR_LO && e.codepoint <= CP_SURR_HI))) begin
            n = cp_utf8_seq(e.codepoint, seq);
            if (pw_len + n < STORE_BYTES) begin
              for (k = 0; k < n; k++) pw_store[pw_len + k] = seq[8*k +: 8];
              pw_len += n;
              pw_count++;
            end
          end
        end
      endcase
    end else if (e.mode == MODE_VERDICT) begin
      if (lock_pending) begin
        lock_pending = 1'b0;
        if (e.verdict_ok) begin
          clear_pw();
          lock_wrong    = 1'b0;
          lock_fails    = 16'd0;
          lock_deadline = 48'd0;
          unl           = 1'b1;
        end else begin
          lock_wrong = 1'b1;
          if (lock_fails < FAIL_MAX) lock_fails++;
          d = backoff_ms();
          if (d > ({16'd0, TIME_MAX} - {16'd0, e.now_ms})) lock_deadline = TIME_MAX;
          else lock_deadline = e.now_ms + d[47:0];
        end
      end
    end else if (e.mode == MODE_ABORT) begin
      clear_pw();
      lock_wrong    = 1'b0;
      lock_fails    = 16'd0;
      lock_deadline = 48'd0;
      lock_pending  = 1'b0;
    end
    lock_words.push_back(status_of(WORD_STATUS, 8'd0, 1'b0, unl, e.now_ms));
  endfunction

  function automatic string word_text(input lock_word_t w);
    return {$sformatf("kind=%0d byte=%h last=%0d count=%0d ",
                      w.result_kind, w.password_byte, w.last_byte, w.typed_count),
            $sformatf("wrong=%0d thr=%0d lock=%0d await=%0d unl=%0d",
                      w.wrong_shown, w.throttled_now, w.lockout_active,
                      w.awaiting_verdict, w.unlocked)};
  endfunction

  function automatic entry_t make_entry(input logic [1:0] m, input logic p,
                                        input logic [2:0] k, input logic [20:0] cp,
                                        input logic ok, input logic [47:0] now);
    entry_t e;
    e.mode        = m;
    e.key_pressed = p;
    e.key_kind    = k;
    e.codepoint   = cp;
    e.verdict_ok  = ok;
    e.now_ms      = now;
    return e;
  endfunction

  function automatic logic [47:0] add_ms(input logic [47:0] t, input int unsigned dt);
    if (TIME_MAX - t < dt) return TIME_MAX;
    return t + dt;
  endfunction

  // clock that mostly crawls, sometimes jumps
  function automatic logic [47:0] next_now();
    if ($urandom_range(7) == 0) cur_ms = add_ms(cur_ms, $urandom_range(10000));
    else cur_ms = add_ms(cur_ms, $urandom_range(300));
    return cur_ms;
  endfunction

  function automatic logic [47:0] now_after_deadline();
    if (lock_deadline > cur_ms) cur_ms = lock_deadline;
    cur_ms = add_ms(cur_ms, $urandom_range(50));
    return cur_ms;
  endfunction

  function automatic logic [20:0] pick_codepoint();
    logic [20:0] cp;
    case ($urandom_range(9))
      4: cp = 21'($urandom_range(21'h7ff, 21'h80));
      5: cp = $urandom_range(1) ? 21'($urandom_range(21'hd7ff, 21'h800))
                                : 21'($urandom_range(21'hffff, 21'he000));
      6: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
      7: begin
        case ($urandom_range(3))
          0: cp = 21'($urandom_range(21'h1f));
          1: cp = CP_DELETE;
          2: cp = 21'($urandom_range(CP_SURR_HI, CP_SURR_LO));
          default: cp = 21'($urandom_range(21'h1fffff, 21'h110000));
        endcase
      end
      8: cp = 21'($urandom);
      default: cp = 21'($urandom_range(21'h7e, 21'h20));
    endcase
    return cp;
  endfunction

  function automatic entry_t noise_entry();
    logic [47:0] t;
    t = $urandom_range(1) ? 48'({$urandom, $urandom}) : next_now();
    return make_entry(2'($urandom_range(3)), 1'($urandom_range(1)), 3'($urandom_range(7)),
                      21'($urandom), 1'($urandom_range(1)), t);
  endfunction

  // drive one input word and wait for it to be taken
  task automatic send_entry(input entry_t e);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode        = e.mode;
    key_pressed = e.key_pressed;
    key_kind    = e.key_kind;
    codepoint   = e.codepoint;
    verdict_ok  = e.verdict_ok;
    now_ms      = e.now_ms;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lock_update(e);
    if (!(e.mode == MODE_UNKNOWN ||
          (e.mode == MODE_KEY && (!e.key_pressed || e.key_kind > KIND_ENTER))))
      fed_words++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (lock_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_DELAY: cfg_base    = val;
      REG_GROWTH:     cfg_growth  = val[7:0];
      REG_MAX_DELAY:  cfg_max     = val;
      REG_MIN_WRONG:  cfg_min     = val;
      REG_LOCKOUT:    cfg_lockout = val[15:0];
      REG_WIPE_ON_BS: cfg_wipe    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_config(input logic [31:0] base, input logic [7:0] growth,
                              input logic [31:0] max_d, input logic [31:0] min_d,
                              input logic [15:0] lockout, input logic wipe);
    pause_until_drained();
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_GROWTH, {24'd0, growth});
    write_reg(REG_MAX_DELAY, max_d);
    write_reg(REG_MIN_WRONG, min_d);
    write_reg(REG_LOCKOUT, {16'd0, lockout});
    write_reg(REG_WIPE_ON_BS, {31'd0, wipe});
  endtask

  // type a password with some edits, submit it, answer the verdict
  task automatic typing_session();
    logic        long_run;
    logic [20:0] cp;
    int          n;
    int          i;
    int          r;
    long_run = ($urandom_range(7) == 0);
    n = long_run ? $urandom_range(24, 16) : $urandom_range(8, 1);
    for (i = 0; i < n; i++) begin
      if (long_run)
        cp = $urandom_range(1) ? 21'($urandom_range(21'h10ffff, 21'h10000))
                               : 21'($urandom_range(21'hd7ff, 21'h800));
      else
        cp = pick_codepoint();
      send_entry(make_entry(MODE_KEY, 1'b1, KIND_CHAR, cp, 1'b0, next_now()));
      r = $urandom_range(99);
      if (r < 12)
        send_entry(make_entry(MODE_KEY, 1'b1, KIND_BACKSPACE, 21'($urandom), 1'b0,
                              next_now()));
      else if (r < 15)
        send_entry(make_entry(MODE_KEY, 1'b1, KIND_ESCAPE, 21'($urandom), 1'b0,
                              next_now()));
      else if (r < 20)
        send_entry(make_entry(MODE_KEY, 1'($urandom_range(1)),
                              $urandom_range(1) ? KIND_MODIFIER : 3'($urandom_range(7)),
                              21'($urandom), 1'b0, next_now()));
    end
    if ($urandom_range(19) == 0) begin
      send_entry(make_entry(MODE_ABORT, 1'b0, KIND_CHAR, 21'd0, 1'b0, next_now()));
      return;
    end
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0,
                          ($urandom_range(4) == 0) ? next_now() : now_after_deadline()));
    if (lock_pending) begin
      if ($urandom_range(9) == 0)
        send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0, next_now()));
      send_entry(make_entry(MODE_VERDICT, 1'b0, KIND_CHAR, 21'd0,
                            $urandom_range(99) < 30, next_now()));
    end
  endtask

  task automatic run_traffic(input int send_pct, input int recv_pct, input int count);
    int   start;
    logic paused;
    idle_pct  = send_pct;
    stall_pct = recv_pct;
    start     = fed_words;
    paused    = 1'b0;
    while (fed_words - start < count) begin
      // one full stop partway through, sender waits for every word out
      if (!paused && fed_words - start >= count / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 70) typing_session();
      else send_entry(noise_entry());
    end
  endtask

  // field extremes, every key kind and mode, refused and stray cases
  task automatic test_edit_and_submit();
    logic [20:0] good_cps [9] = '{21'h41, 21'h20, 21'h7e, 21'h80, 21'h7ff, 21'h800,
                                  21'hffff, 21'h10000, 21'h10ffff};
    logic [20:0] bad_cps  [7] = '{21'h0, 21'h1f, 21'h7f, 21'hd800, 21'hdfff, 21'h110000,
                                  21'h1fffff};
    foreach (good_cps[i])
      send_entry(make_entry(MODE_KEY, 1'b1, KIND_CHAR, good_cps[i], 1'b0, 48'd0));
    foreach (bad_cps[i])
      send_entry(make_entry(MODE_KEY, 1'b1, KIND_CHAR, bad_cps[i], 1'b0, 48'd0));
    send_entry(make_entry(MODE_KEY, 1'b0, KIND_CHAR, 21'h42, 1'b0, 48'd0));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_MODIFIER, 21'h43, 1'b0, 48'd0));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_RESERVED, 21'h44, 1'b0, 48'd0));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_BACKSPACE, 21'd0, 1'b0, 48'd0));
    send_entry(make_entry(MODE_VERDICT, 1'b0, KIND_CHAR, 21'd0, 1'b1, 48'd0));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0, 48'd0));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_CHAR, 21'h78, 1'b0, 48'd1));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0, 48'd2));
    // deadline saturates at the top of the time range
    send_entry(make_entry(MODE_VERDICT, 1'b0, KIND_CHAR, 21'd0, 1'b0, TIME_MAX - 48'd5));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0, 48'd100));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ESCAPE, 21'd0, 1'b0, TIME_MAX));
    send_entry(make_entry(MODE_UNKNOWN, 1'b1, KIND_ENTER, 21'h1fffff, 1'b1, TIME_MAX));
    send_entry(make_entry(MODE_ABORT, 1'b0, KIND_CHAR, 21'd0, 1'b0, 48'd200));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0, 48'd300));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_CHAR, 21'h79, 1'b0, 48'd400));
    send_entry(make_entry(MODE_KEY, 1'b1, KIND_ENTER, 21'd0, 1'b0, 48'd500));
    send_entry(make_entry(MODE_VERDICT, 1'b0, KIND_CHAR, 21'd0, 1'b1, 48'd600));
    cur_ms = 48'd1000;
  endtask

  task automatic test_growth_to_lockout();
    apply_config(32'd10, 8'd3, 32'd5000, 32'd50, 16'd4, 1'b0);
    run_traffic(0, 0, 125);
  endtask

  task automatic test_unit_growth_sender_gaps();
    apply_config(32'd1, 8'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0);
    run_traffic(84, 0, 125);
  endtask

  task automatic test_extreme_config_receiver_stall();
    apply_config(32'hFFFF_FFFF, 8'hFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    run_traffic(0, 84, 125);
  endtask

  task automatic test_instant_lockout_mixed_idle();
    apply_config(32'd100, 8'd2, 32'd60000, 32'd1000, 16'd1, 1'b1);
    run_traffic(20, 20, 125);
  endtask

  // receiver backpressure
  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  // check each output word against the oldest prediction
  always @(posedge clk) begin
    lock_word_t got;
    lock_word_t want;
    if (!rst && out_valid && !out_stall) begin
      got.result_kind      = result_kind;
      got.password_byte    = password_byte;
      got.last_byte        = last_byte;
      got.typed_count      = typed_count;
      got.wrong_shown      = wrong_shown;
      got.throttled_now    = throttled_now;
      got.lockout_active   = lockout_active;
      got.awaiting_verdict = awaiting_verdict;
      got.unlocked         = unlocked;
      if (lock_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", word_text(got));
      end else begin
        want = lock_words.pop_front();
        if (got.result_kind !== want.result_kind || got.password_byte !== want.password_byte ||
            got.last_byte !== want.last_byte || got.typed_count !== want.typed_count ||
            got.wrong_shown !== want.wrong_shown || got.throttled_now !== want.throttled_now ||
            got.lockout_active !== want.lockout_active ||
            got.awaiting_verdict !== want.awaiting_verdict ||
            got.unlocked !== want.unlocked) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp %s", word_text(want));
            $display("          act %s", word_text(got));
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = MODE_KEY;
    key_pressed = 1'b0;
    key_kind    = KIND_CHAR;
    codepoint   = 21'd0;
    verdict_ok  = 1'b0;
    now_ms      = 48'd0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_BASE_DELAY;
    cfg_data    = 32'd0;
    clear_pw();
    lock_wrong    = 1'b0;
    lock_fails    = 16'd0;
    lock_deadline = 48'd0;
    lock_pending  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_edit_and_submit();
    test_growth_to_lockout();
    test_unit_growth_sender_gaps();
    test_extreme_config_receiver_stall();
    test_instant_lockout_mixed_idle();
    pause_until_drained();

    if (mismatches == 0 && lock_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pebl_pkg.sv
hw/rtl/pebl_ctrl.sv
hw/rtl/pebl_dp.sv
hw/rtl/password_entry_backoff_lock.sv
tb/sv/testbench.sv
